### sv/vhdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vhdp_pkg;

	// stream length limit; later bytes are dropped, the last flag still ends the stream
	localparam int unsigned MAX_STREAM_BYTES = 1048576;
	localparam int unsigned CNT_W            = $clog2(MAX_STREAM_BYTES + 1);
	// marker offset may run one maximal segment past the limit
	localparam int unsigned OFF_W            = $clog2(MAX_STREAM_BYTES + 65537);

	localparam int unsigned HDR_LEN   = 20;
	localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);

	localparam int unsigned DIM_W    = 13;
	localparam int unsigned FRAMES_W = 14;
	localparam int unsigned FPS_W    = 7;
	localparam int unsigned KIND_W   = 3;

	localparam logic [31:0] SIG_MAIN      = 32'h47504A4D;
	localparam logic [31:0] SIG_MAIN_SWAP = 32'h4D4A5047;
	localparam logic [31:0] SIG_ALT       = 32'hFEFFD8FF;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] CODE_SOI    = 8'hD8;
	localparam logic [7:0] CODE_EOI    = 8'hD9;
	localparam logic [7:0] CODE_SOF_LO = 8'hC0;
	localparam logic [7:0] CODE_SOF_HI = 8'hCF;
	localparam logic [7:0] CODE_DHT    = 8'hC4;
	localparam logic [7:0] CODE_JPG    = 8'hC8;

	localparam logic [31:0] DIM_MAX     = 32'd4096;
	localparam logic [31:0] FRAMES_MAX  = 32'd10000;
	localparam logic [31:0] FPS_MAX     = 32'd120;
	localparam logic [31:0] DEF_WIDTH   = 32'd320;
	localparam logic [31:0] DEF_HEIGHT  = 32'd240;
	localparam logic [31:0] DEF_FRAMES  = 32'd100;
	localparam logic [31:0] DEF_FPS     = 32'd30;

	typedef enum logic [KIND_W-1:0] {
		KIND_JPEG_SOF     = 3'd0,
		KIND_JPEG_DEFAULT = 3'd1,
		KIND_CONTAINER    = 3'd2,
		KIND_SWAPPED      = 3'd3,
		KIND_ADJUSTED     = 3'd4,
		KIND_TOO_SHORT    = 3'd5
	} header_kind_t;

endpackage

`default_nettype wire

### sv/vhdp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vhdp_stream_if;
	import vhdp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       last_byte;

	modport source (output valid, output stream_byte, output last_byte, input ready);
	modport sink (input valid, input stream_byte, input last_byte, output ready);

endinterface

`default_nettype wire

### sv/vhdp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vhdp_result_if;
	import vhdp_pkg::*;

	logic                valid;
	logic                ready;
	logic [DIM_W-1:0]    video_width;
	logic [DIM_W-1:0]    video_height;
	logic [FRAMES_W-1:0] total_frames;
	logic [FPS_W-1:0]    frames_per_second;
	logic [KIND_W-1:0]   header_kind;
	logic                parse_ok;

	modport source (output valid, output video_width, output video_height,
		output total_frames, output frames_per_second, output header_kind,
		output parse_ok, input ready);
	modport sink (input valid, input video_width, input video_height,
		input total_frames, input frames_per_second, input header_kind,
		input parse_ok, output ready);

endinterface

`default_nettype wire

### sv/video_header_dimension_parser_core.sv
// Video header dimension parser: one stream byte per beat, one result beat per stream.
// Throughput: one byte beat per cycle; bytes stall only while s1 and the result are both held.
// The beat carrying last_byte loads s1; s1 moves into the result register once that is free.
// Reset (arst_n low, async): counters, scan state and both valid flags clear;
// the 20-byte header store holds no reset; each stream rewrites it up to its own length.
`timescale 1ns / 1ps
`default_nettype none

module video_header_dimension_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	vhdp_stream_if.sink        stream,
	vhdp_result_if.source      result
);
	import vhdp_pkg::*;

	// JPEG segment walk
	//   SCAN_SEEK  : reading marker, code, length of the segment at next_off_q
	//   SCAN_SOF   : SOF seen, collecting height/width bytes
	//   SCAN_FOUND : valid dimensions held (width low byte sits in marker_q)
	//   SCAN_STOP  : gave up, defaults apply
	typedef enum logic [1:0] {
		SCAN_SEEK  = 2'd0,
		SCAN_SOF   = 2'd1,
		SCAN_FOUND = 2'd2,
		SCAN_STOP  = 2'd3
	} scan_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [FRAMES_W-1:0] frames;
		logic [FPS_W-1:0]    fps;
		header_kind_t        kind;
		logic                ok;
	} res_t;

	// ---------------------------------------------------------------------
	// Stream state
	// ---------------------------------------------------------------------
	logic [CNT_W-1:0] count_q,    count_n;
	logic [OFF_W-1:0] next_off_q, next_off_n;
	logic [7:0]       marker_q,   marker_n;
	logic [7:0]       len_hi_q,   len_hi_n;
	logic [15:0]      sof_h_q,    sof_h_n;
	logic [7:0]       sof_wh_q,   sof_wh_n;
	scan_state_t      scan_q,     scan_n;

	logic [7:0] header_q [HDR_LEN];

	// pipeline: s1 holds the end-of-stream snapshot, res_q the result beat
	logic             s1_valid_q;
	logic             ok_s1;
	logic             found_s1;
	logic [DIM_W-1:0] sof_w_s1;
	logic [DIM_W-1:0] sof_h_s1;

	logic res_valid_q;
	res_t res_q;
	res_t res_d;

	// ---------------------------------------------------------------------
	// Handshake: result register frees when taken, s1 moves into it,
	// a new beat comes in whenever s1 is empty or moving on.
	// ---------------------------------------------------------------------
	logic out_free;
	logic s1_adv;
	logic acc;

	assign out_free     = !res_valid_q || result.ready;
	assign s1_adv       = s1_valid_q && out_free;
	assign stream.ready = !s1_valid_q || out_free;
	assign acc          = stream.valid && stream.ready;

	// ---------------------------------------------------------------------
	// Per-byte scan update
	// ---------------------------------------------------------------------
	logic [7:0]       b;
	logic             live;
	logic [OFF_W-1:0] cnt_ext;
	logic             in_win;
	logic [OFF_W-1:0] rel;
	logic [15:0]      seg_len;
	logic [15:0]      w16;
	logic             is_sof;
	logic             dims_ok;
	logic             ok_n;
	logic [15:0]      sof_w_n;

	assign b       = stream.stream_byte;
	assign live    = count_q < CNT_W'(MAX_STREAM_BYTES);
	assign cnt_ext = OFF_W'(count_q);
	assign in_win  = cnt_ext >= next_off_q;
	assign rel     = cnt_ext - next_off_q;
	assign seg_len = {len_hi_q, b};
	assign w16     = {sof_wh_q, b};

	always_comb begin
		is_sof = 1'b0;
		if (marker_q == MARK_PREFIX && b != CODE_DHT && b != CODE_JPG) begin
			is_sof = b inside {[CODE_SOF_LO:CODE_SOF_HI]};
		end
	end

	assign dims_ok = (w16 != 16'd0) && (w16 <= DIM_MAX[15:0]) &&
	                 (sof_h_q != 16'd0) && (sof_h_q <= DIM_MAX[15:0]);

	always_comb begin
		count_n    = count_q;
		next_off_n = next_off_q;
		marker_n   = marker_q;
		len_hi_n   = len_hi_q;
		sof_h_n    = sof_h_q;
		sof_wh_n   = sof_wh_q;
		scan_n     = scan_q;
		if (live) begin
			count_n = count_q + CNT_W'(1);
			if (in_win) begin
				case (scan_q)
					SCAN_SEEK: begin
						if (rel == OFF_W'(0)) begin
							marker_n = b;
						end else if (rel == OFF_W'(1)) begin
							if (is_sof) begin
								scan_n = SCAN_SOF;
							end else if (b inside {CODE_SOI, CODE_EOI}) begin
								// standalone marker, no length field
								next_off_n = next_off_q + OFF_W'(2);
							end
						end else if (rel == OFF_W'(2)) begin
							len_hi_n = b;
						end else if (rel == OFF_W'(3)) begin
							next_off_n = next_off_q + OFF_W'(2) + OFF_W'(seg_len);
							// length 0 or 1: next marker overlaps the length bytes,
							// the low length byte becomes the new marker byte
							if (seg_len <= 16'd1) begin
								marker_n = b;
							end
						end
					end
					SCAN_SOF: begin
						if (rel == OFF_W'(5)) begin
							sof_h_n = {b, 8'd0};
						end else if (rel == OFF_W'(6)) begin
							sof_h_n = {sof_h_q[15:8], b};
						end else if (rel == OFF_W'(7)) begin
							sof_wh_n = b;
						end else if (rel == OFF_W'(8)) begin
							if (dims_ok) begin
								marker_n = b;
								scan_n   = SCAN_FOUND;
							end else begin
								scan_n = SCAN_STOP;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign ok_n    = count_n >= CNT_W'(HDR_LEN);
	assign sof_w_n = {sof_wh_n, marker_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			next_off_q <= OFF_W'(2);
			marker_q   <= '0;
			len_hi_q   <= '0;
			sof_h_q    <= '0;
			sof_wh_q   <= '0;
			scan_q     <= SCAN_SEEK;
		end else if (acc) begin
			if (stream.last_byte) begin
				// stream done, back to the start-of-stream state
				count_q    <= '0;
				next_off_q <= OFF_W'(2);
				marker_q   <= '0;
				len_hi_q   <= '0;
				sof_h_q    <= '0;
				sof_wh_q   <= '0;
				scan_q     <= SCAN_SEEK;
			end else begin
				count_q    <= count_n;
				next_off_q <= next_off_n;
				marker_q   <= marker_n;
				len_hi_q   <= len_hi_n;
				sof_h_q    <= sof_h_n;
				sof_wh_q   <= sof_wh_n;
				scan_q     <= scan_n;
			end
		end
	end

	// first 20 bytes of the stream
	always_ff @(posedge clk) begin
		if (acc && count_q < CNT_W'(HDR_LEN)) begin
			header_q[count_q[HDR_IDX_W-1:0]] <= b;
		end
	end

	// ---------------------------------------------------------------------
	// s1: end-of-stream snapshot of the scan. The header store is read
	// directly in this stage; the next stream cannot overwrite it before
	// s1 has moved into the result register.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc && stream.last_byte) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && stream.last_byte) begin
			ok_s1    <= ok_n;
			found_s1 <= (scan_n == SCAN_FOUND);
			sof_w_s1 <= sof_w_n[DIM_W-1:0];
			sof_h_s1 <= sof_h_n[DIM_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Header decode
	// ---------------------------------------------------------------------
	function automatic logic [31:0] swap32(input logic [31:0] v);
		swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic in_range(input logic [31:0] v, input logic [31:0] max_v);
		in_range = (v != 32'd0) && (v <= max_v);
	endfunction

	// out of range: try the byte-swapped value, then the default
	function automatic logic [31:0] fix_field(input logic [31:0] v,
		input logic [31:0] max_v, input logic [31:0] dflt);
		logic [31:0] sw;
		sw = swap32(v);
		if (in_range(v, max_v)) begin
			fix_field = v;
		end else if (in_range(sw, max_v)) begin
			fix_field = sw;
		end else begin
			fix_field = dflt;
		end
	endfunction

	always_comb begin
		logic [31:0] words [5];
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] fc;
		logic [31:0] fps;
		logic        swapped;
		header_kind_t kind;

		for (int k = 0; k < 5; k++) begin
			words[k] = {header_q[4*k+3], header_q[4*k+2], header_q[4*k+1], header_q[4*k]};
		end
		swapped = (words[0] == SIG_MAIN_SWAP);
		w       = 32'd0;
		h       = 32'd0;
		fc      = 32'd0;
		fps     = 32'd0;
		kind    = KIND_TOO_SHORT;

		if (ok_s1) begin
			if (header_q[0] == MARK_PREFIX && header_q[1] == CODE_SOI) begin
				fc  = 32'd1;
				fps = DEF_FPS;
				if (found_s1) begin
					kind = KIND_JPEG_SOF;
					w    = 32'(sof_w_s1);
					h    = 32'(sof_h_s1);
				end else begin
					kind = KIND_JPEG_DEFAULT;
					w    = DEF_WIDTH;
					h    = DEF_HEIGHT;
				end
			end else if (words[0] != SIG_MAIN && !swapped && words[0] != SIG_ALT) begin
				kind = KIND_ADJUSTED;
				w    = fix_field(words[1], DIM_MAX, DEF_WIDTH);
				h    = fix_field(words[2], DIM_MAX, DEF_HEIGHT);
				fc   = fix_field(words[3], FRAMES_MAX, DEF_FRAMES);
				fps  = fix_field(words[4], FPS_MAX, DEF_FPS);
			end else begin
				kind = swapped ? KIND_SWAPPED : KIND_CONTAINER;
				w    = swapped ? swap32(words[1]) : words[1];
				h    = swapped ? swap32(words[2]) : words[2];
				fc   = swapped ? swap32(words[3]) : words[3];
				fps  = swapped ? swap32(words[4]) : words[4];
				// dimensions fall back as a pair
				if (!in_range(w, DIM_MAX) || !in_range(h, DIM_MAX)) begin
					w = DEF_WIDTH;
					h = DEF_HEIGHT;
				end
				if (!in_range(fc, FRAMES_MAX)) begin
					fc = DEF_FRAMES;
				end
				if (!in_range(fps, FPS_MAX)) begin
					fps = DEF_FPS;
				end
			end
		end

		res_d.width  = w[DIM_W-1:0];
		res_d.height = h[DIM_W-1:0];
		res_d.frames = fc[FRAMES_W-1:0];
		res_d.fps    = fps[FPS_W-1:0];
		res_d.kind   = kind;
		res_d.ok     = ok_s1;
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.video_width       = res_q.width;
	assign result.video_height      = res_q.height;
	assign result.total_frames      = res_q.frames;
	assign result.frames_per_second = res_q.fps;
	assign result.header_kind       = res_q.kind;
	assign result.parse_ok          = res_q.ok;

endmodule

`default_nettype wire

### dv/vhdp_dims_checker.sv
`timescale 1ns / 1ps

module vhdp_dims_checker
	import vhdp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	vhdp_stream_if stream_mon,
	vhdp_result_if result_mon,
	output int     fail_count,
	output int     dims_pending
);

	typedef struct packed {
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [FRAMES_W-1:0] frames;
		logic [FPS_W-1:0]    fps;
		header_kind_t        kind;
		logic                ok;
	} dims_t;

	typedef enum logic [1:0] {
		WALK_SCANNING,
		WALK_SOF_SEEN,
		WALK_DIMS_OK,
		WALK_STOPPED
	} walk_t;

	dims_t       dims_due [$];

	// shadow of the stream state
	logic [31:0] bytes_seen;
	logic [7:0]  hdr_store [HDR_LEN];
	logic [31:0] seg_start;
	logic [7:0]  code_or_wlo;  // marker byte while walking, width low byte once dims are good
	logic [7:0]  len_hi;
	logic [15:0] sof_h;
	logic [7:0]  sof_w_hi;
	walk_t       walk_state;

	function automatic logic [31:0] byte_reverse(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] hdr_word(int k);
		return {hdr_store[4*k+3], hdr_store[4*k+2], hdr_store[4*k+1], hdr_store[4*k]};
	endfunction

	// out of range: try the other byte order, then the default
	function automatic logic [31:0] fall_back(logic [31:0] v, logic [31:0] lim,
		logic [31:0] dflt);
		if (v == 0 || v > lim) begin
			v = byte_reverse(v);
			if (v == 0 || v > lim)
				v = dflt;
		end
		return v;
	endfunction

	task automatic restart_stream();
		bytes_seen  = '0;
		seg_start   = 32'd2;
		code_or_wlo = '0;
		len_hi      = '0;
		sof_h       = '0;
		sof_w_hi    = '0;
		walk_state  = WALK_SCANNING;
	endtask

	// marker, code and length-high bytes of the segment being walked
	task automatic walk_head(input logic [31:0] pos, input logic [7:0] b);
		logic [31:0] rel;
		if (walk_state != WALK_SCANNING || pos < seg_start)
			return;
		rel = pos - seg_start;
		if (rel == 0) begin
			code_or_wlo = b;
		end else if (rel == 1) begin
			if (code_or_wlo == MARK_PREFIX && b >= CODE_SOF_LO && b <= CODE_SOF_HI &&
				b != CODE_DHT && b != CODE_JPG)
				walk_state = WALK_SOF_SEEN;
			else if (b == CODE_SOI || b == CODE_EOI)
				seg_start = seg_start + 32'd2;
		end else if (rel == 2) begin
			len_hi = b;
		end
	endtask

	task automatic walk_byte(input logic [31:0] pos, input logic [7:0] b);
		logic [31:0] rel;
		logic [31:0] prev;
		logic [7:0]  hi;
		logic [31:0] w;
		if (pos < seg_start)
			return;
		rel = pos - seg_start;
		case (walk_state)
			WALK_SCANNING: begin
				if (rel <= 2) begin
					walk_head(pos, b);
				end else if (rel == 3) begin
					prev      = seg_start;
					hi        = len_hi;
					seg_start = prev + 32'd2 + {16'd0, hi, b};
					// lengths 0 and 1 land the next marker on the length bytes
					if (seg_start <= prev + 32'd2)
						walk_head(prev + 32'd2, hi);
					if (seg_start <= prev + 32'd3)
						walk_head(prev + 32'd3, b);
				end
			end
			WALK_SOF_SEEN: begin
				if (rel == 5) begin
					sof_h = {b, 8'd0};
				end else if (rel == 6) begin
					sof_h = sof_h | {8'd0, b};
				end else if (rel == 7) begin
					sof_w_hi = b;
				end else if (rel == 8) begin
					w = {16'd0, sof_w_hi, b};
					if (w > 0 && w <= DIM_MAX && sof_h > 0 && sof_h <= DIM_MAX) begin
						code_or_wlo = b;
						walk_state  = WALK_DIMS_OK;
					end else begin
						walk_state = WALK_STOPPED;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic take_byte(input logic [7:0] b, input logic fin);
		dims_t       d;
		logic [31:0] sig;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] fc;
		logic [31:0] fps;
		if (bytes_seen < MAX_STREAM_BYTES) begin
			if (bytes_seen < HDR_LEN)
				hdr_store[bytes_seen] = b;
			walk_byte(bytes_seen, b);
			bytes_seen = bytes_seen + 1;
		end
		if (!fin)
			return;
		w   = '0;
		h   = '0;
		fc  = '0;
		fps = '0;
		d   = '0;
		d.kind = KIND_TOO_SHORT;
		if (bytes_seen >= HDR_LEN) begin
			d.ok = 1'b1;
			if (hdr_store[0] == MARK_PREFIX && hdr_store[1] == CODE_SOI) begin
				fc  = 32'd1;
				fps = DEF_FPS;
				if (walk_state == WALK_DIMS_OK) begin
					d.kind = KIND_JPEG_SOF;
					w      = {16'd0, sof_w_hi, code_or_wlo};
					h      = {16'd0, sof_h};
				end else begin
					d.kind = KIND_JPEG_DEFAULT;
					w      = DEF_WIDTH;
					h      = DEF_HEIGHT;
				end
			end else begin
				sig = hdr_word(0);
				w   = hdr_word(1);
				h   = hdr_word(2);
				fc  = hdr_word(3);
				fps = hdr_word(4);
				if (sig != SIG_MAIN && sig != SIG_MAIN_SWAP && sig != SIG_ALT) begin
					d.kind = KIND_ADJUSTED;
					w      = fall_back(w, DIM_MAX, DEF_WIDTH);
					h      = fall_back(h, DIM_MAX, DEF_HEIGHT);
					fc     = fall_back(fc, FRAMES_MAX, DEF_FRAMES);
					fps    = fall_back(fps, FPS_MAX, DEF_FPS);
				end else begin
					d.kind = KIND_CONTAINER;
					if (sig == SIG_MAIN_SWAP) begin
						d.kind = KIND_SWAPPED;
						w      = byte_reverse(w);
						h      = byte_reverse(h);
						fc     = byte_reverse(fc);
						fps    = byte_reverse(fps);
					end
					if (w == 0 || w > DIM_MAX || h == 0 || h > DIM_MAX) begin
						w = DEF_WIDTH;
						h = DEF_HEIGHT;
					end
					if (fc == 0 || fc > FRAMES_MAX)
						fc = DEF_FRAMES;
					if (fps == 0 || fps > FPS_MAX)
						fps = DEF_FPS;
				end
			end
		end
		d.width  = w[DIM_W-1:0];
		d.height = h[DIM_W-1:0];
		d.frames = fc[FRAMES_W-1:0];
		d.fps    = fps[FPS_W-1:0];
		dims_due.push_back(d);
		restart_stream();
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dims_t want;
		if (!arst_n) begin
			restart_stream();
			dims_due.delete();
			fail_count = 0;
		end else begin
			if (stream_mon.valid && stream_mon.ready)
				take_byte(stream_mon.stream_byte, stream_mon.last_byte);
			if (result_mon.valid && result_mon.ready) begin
				if (dims_due.size() == 0) begin
					$error("result beat with no stream waiting for it");
					fail_count++;
				end else begin
					want = dims_due.pop_front();
					compare_field("video_width", want.width, result_mon.video_width);
					compare_field("video_height", want.height, result_mon.video_height);
					compare_field("total_frames", want.frames, result_mon.total_frames);
					compare_field("frames_per_second", want.fps, result_mon.frames_per_second);
					compare_field("header_kind", want.kind, result_mon.header_kind);
					compare_field("parse_ok", want.ok, result_mon.parse_ok);
				end
			end
		end
		dims_pending = dims_due.size();
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import vhdp_pkg::*;

	logic       clk;
	logic       arst_n;
	int         fail_count;
	int         dims_pending;
	int         bytes_sent;
	int         burst_left;
	int         stall_left;
	int         stall_mode;
	logic [7:0] stream_bytes [$];  // stream under construction, offset 0 first

	vhdp_stream_if stream_ch ();
	vhdp_result_if result_ch ();

	video_header_dimension_parser_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	// watches both channels, predicts each result and counts mismatches
	vhdp_dims_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_mon   (stream_ch),
		.result_mon   (result_ch),
		.fail_count   (fail_count),
		.dims_pending (dims_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop; a clean run needs well under a tenth of this
	initial begin
		#(5_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	// Result side backpressure. Stretches of random length, each with its own
	// behavior: always ready, coin-flip ready, or held off until the stretch ends.
	// The result path is two deep, so the held-off stretches also push back on
	// the byte channel once short streams pile up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(4, 60);
			end
			stall_left--;
			case (stall_mode)
				0, 1:    result_ch.ready <= 1'b1;
				2:       result_ch.ready <= 1'($urandom_range(0, 1));
				default: result_ch.ready <= (stall_left == 0);
			endcase
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	function automatic logic [31:0] byte_flip(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic void add_be16(logic [15:0] v);
		stream_bytes.push_back(v[15:8]);
		stream_bytes.push_back(v[7:0]);
	endfunction

	function automatic void add_le32(logic [31:0] v);
		for (int k = 0; k < 4; k++)
			stream_bytes.push_back(v[8*k +: 8]);
	endfunction

	function automatic void add_noise(int n);
		repeat (n) stream_bytes.push_back(8'($urandom));
	endfunction

	// container field: a random in-range value, plus zero, one, the limit, one past it,
	// the other byte order and raw 32-bit noise
	function automatic logic [31:0] pick_count(logic [31:0] lim);
		logic [31:0] v;
		v = $urandom_range(1, lim);
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = 32'd1;
			2:       v = lim;
			3:       v = lim + 1;
			4:       v = byte_flip(v);
			5:       v = $urandom;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_sof_dim();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'd4096;
			3:       return 16'd4097;
			4:       return 16'($urandom);
			default: return 16'($urandom_range(1, 4096));
		endcase
	endfunction

	// 20-byte little-endian header; the signature is good, swapped, the
	// alternate one, one bit off, or noise
	function automatic void build_container();
		logic [31:0] sig;
		logic        flip;
		case ($urandom_range(0, 4))
			0:       sig = SIG_MAIN;
			1:       sig = SIG_MAIN_SWAP;
			2:       sig = SIG_ALT;
			3:       sig = SIG_MAIN ^ (32'd1 << $urandom_range(0, 31));
			default: sig = $urandom;
		endcase
		// a swapped header mostly carries swapped fields as well
		flip = (sig == SIG_MAIN_SWAP) && ($urandom_range(0, 3) != 0);
		add_le32(sig);
		add_le32(flip ? byte_flip(pick_count(DIM_MAX)) : pick_count(DIM_MAX));
		add_le32(flip ? byte_flip(pick_count(DIM_MAX)) : pick_count(DIM_MAX));
		add_le32(flip ? byte_flip(pick_count(FRAMES_MAX)) : pick_count(FRAMES_MAX));
		add_le32(flip ? byte_flip(pick_count(FPS_MAX)) : pick_count(FPS_MAX));
		add_noise($urandom_range(0, 6));
	endfunction

	// SOI, a few segments (some malformed), then usually an SOF segment
	function automatic void build_jpeg();
		int         seg_len;
		int         sof_at;
		int         cut;
		logic [7:0] code;
		cut = 0;
		stream_bytes.push_back(MARK_PREFIX);
		stream_bytes.push_back(CODE_SOI);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 9))
				0: begin
					// bare marker with no length
					stream_bytes.push_back(MARK_PREFIX);
					stream_bytes.push_back($urandom_range(0, 1) ? CODE_SOI : CODE_EOI);
				end
				1: begin
					// length 0 or 1: next marker overlaps the length bytes
					stream_bytes.push_back(MARK_PREFIX);
					stream_bytes.push_back(8'hE0 + 8'($urandom_range(0, 15)));
					add_be16(16'($urandom_range(0, 1)));
				end
				2: begin
					// marker byte that is not FF; walked by its length anyway
					stream_bytes.push_back(8'($urandom_range(0, 254)));
					stream_bytes.push_back(8'($urandom));
					seg_len = $urandom_range(2, 8);
					add_be16(16'(seg_len));
					add_noise(seg_len - 2);
				end
				default: begin
					stream_bytes.push_back(MARK_PREFIX);
					if ($urandom_range(0, 3) == 0)
						code = $urandom_range(0, 1) ? CODE_DHT : CODE_JPG;
					else
						code = 8'($urandom_range(8'hE0, 8'hFE));
					stream_bytes.push_back(code);
					seg_len = $urandom_range(2, 12);
					add_be16(16'(seg_len));
					add_noise(seg_len - 2);
				end
			endcase
		end
		if ($urandom_range(0, 7) != 0) begin
			if ($urandom_range(0, 5) == 0) begin
				// stream will end around the SOF dimension bytes; push the
				// SOF far enough out that the stream still makes 20 bytes
				while (stream_bytes.size() < 14) begin
					stream_bytes.push_back(MARK_PREFIX);
					stream_bytes.push_back(8'hE1);
					add_be16(16'd8);
					add_noise(6);
				end
				cut = 1;
			end
			sof_at = stream_bytes.size();
			do code = 8'($urandom_range(CODE_SOF_LO, CODE_SOF_HI));
			while (code == CODE_DHT || code == CODE_JPG);
			stream_bytes.push_back(MARK_PREFIX);
			stream_bytes.push_back(code);
			add_be16(16'd17);
			stream_bytes.push_back(8'd8);
			add_be16(pick_sof_dim());
			add_be16(pick_sof_dim());
			add_noise($urandom_range(0, 10));
			if (cut != 0) begin
				// last byte lands on the height or width bytes, up to the width low byte
				cut = sof_at + $urandom_range(6, 9);
				while (stream_bytes.size() > cut)
					void'(stream_bytes.pop_back());
			end
		end
		if (cut == 0)
			while (stream_bytes.size() < 20)
				stream_bytes.push_back(8'($urandom));
	endfunction

	// Sends the stream in stream_bytes, last flag on its final byte. The sender
	// runs in bursts; a gap of idle cycles may come between bursts, so gaps land
	// on any byte offset of any stream.
	task automatic send_stream();
		int gap;
		foreach (stream_bytes[k]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
				if (gap != 0) begin
					stream_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				                                         : $urandom_range(1, 12);
			end
			stream_ch.valid       <= 1'b1;
			stream_ch.stream_byte <= stream_bytes[k];
			stream_ch.last_byte   <= (k == stream_bytes.size() - 1);
			@(posedge clk);
			while (!stream_ch.ready) @(posedge clk);
			burst_left--;
			bytes_sent++;
		end
		stream_bytes.delete();
	endtask

	initial begin
		arst_n                = 1'b0;
		stream_ch.valid       = 1'b0;
		stream_ch.stream_byte = '0;
		stream_ch.last_byte   = 1'b0;
		bytes_sent            = 0;
		burst_left            = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// single beat stream: too short, all-ones byte
		stream_bytes.push_back(8'hFF);
		send_stream();
		// exact 20-byte container at the field limits
		add_le32(SIG_MAIN);
		add_le32(DIM_MAX);
		add_le32(32'd1);
		add_le32(FRAMES_MAX);
		add_le32(FPS_MAX);
		send_stream();

		// Random streams. JPEG streams dominate since the segment walk is the
		// deep part; containers hit the signature and field fallback paths;
		// noise and short streams cover the rest, short ones often arriving
		// back to back to fill the result pipeline.
		while (bytes_sent < 1850) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: build_jpeg();
				8, 9, 10, 11, 12:       build_container();
				13, 14, 15: begin
					add_noise($urandom_range(20, 48));
					if ($urandom_range(0, 2) == 0) begin
						stream_bytes[0] = MARK_PREFIX;
						stream_bytes[1] = CODE_SOI;
					end
				end
				default: begin
					add_noise($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 19));
					if (stream_bytes.size() >= 2 && $urandom_range(0, 3) == 0) begin
						stream_bytes[0] = MARK_PREFIX;
						stream_bytes[1] = CODE_SOI;
					end
				end
			endcase
			send_stream();
		end
		stream_ch.valid <= 1'b0;

		// drain, then give the two-stage result path time to show anything extra
		@(posedge clk);
		while (dims_pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### sim.f
sv/vhdp_pkg.sv
sv/vhdp_stream_if.sv
sv/vhdp_result_if.sv
sv/video_header_dimension_parser_core.sv
dv/vhdp_dims_checker.sv
dv/tb_top.sv
